// File: rtl/iics_pkg.sv
package iics_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int MAX_RESULTS = 17;

   localparam logic [2:0] REQ_ADD      = 3'd0;
   localparam logic [2:0] REQ_CONTAINS = 3'd1;
   localparam logic [2:0] REQ_COVERED  = 3'd2;
   localparam logic [2:0] REQ_LARGEST  = 3'd3;
   localparam logic [2:0] REQ_LIST     = 3'd4;
   localparam logic [2:0] REQ_CLEAR    = 3'd5;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_BAD = 2'd1;

   localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

   localparam logic [4:0] C_NONE    = 5'd0;
   localparam logic [4:0] C_LOAD    = 5'd1;
   localparam logic [4:0] C_START   = 5'd2;
   localparam logic [4:0] C_FIND    = 5'd3;
   localparam logic [4:0] C_SPAN    = 5'd4;
   localparam logic [4:0] C_MERGE   = 5'd5;
   localparam logic [4:0] C_COMPACT = 5'd6;
   localparam logic [4:0] C_CEND    = 5'd7;
   localparam logic [4:0] C_NEWSUM  = 5'd8;
   localparam logic [4:0] C_JSCAN   = 5'd9;
   localparam logic [4:0] C_JWRITE  = 5'd10;
   localparam logic [4:0] C_INSST   = 5'd11;
   localparam logic [4:0] C_INSSH   = 5'd12;
   localparam logic [4:0] C_INSWR   = 5'd13;
   localparam logic [4:0] C_OK      = 5'd14;
   localparam logic [4:0] C_BAD     = 5'd15;
   localparam logic [4:0] C_CLEAR   = 5'd16;
   localparam logic [4:0] C_QSCAN   = 5'd17;
   localparam logic [4:0] C_QTAIL   = 5'd18;
   localparam logic [4:0] C_QFINAL  = 5'd19;

   typedef struct packed {
      logic [4:0] code;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       add_ok;
      logic       find_more;
      logic       span_more;
      logic       span_any;
      logic       full;
      logic       idx_lt;
      logic       ins_more;
      logic       swallowed;
      logic       hold;
      logic       out_free;
   } stat_type;

endpackage

// File: rtl/iics_ctrl.sv
module iics_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  iics_pkg::stat_type stat,
   output iics_pkg::cmd_type  cmd
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_START   = 5'd1;
   localparam logic [4:0] S_FIND    = 5'd2;
   localparam logic [4:0] S_SPAN    = 5'd3;
   localparam logic [4:0] S_MERGE   = 5'd4;
   localparam logic [4:0] S_COMPACT = 5'd5;
   localparam logic [4:0] S_CEND    = 5'd6;
   localparam logic [4:0] S_NEWSUM  = 5'd7;
   localparam logic [4:0] S_JSCAN   = 5'd8;
   localparam logic [4:0] S_JWRITE  = 5'd9;
   localparam logic [4:0] S_FIND2   = 5'd10;
   localparam logic [4:0] S_INSST   = 5'd11;
   localparam logic [4:0] S_INSSH   = 5'd12;
   localparam logic [4:0] S_INSWR   = 5'd13;
   localparam logic [4:0] S_OK      = 5'd14;
   localparam logic [4:0] S_BAD     = 5'd15;
   localparam logic [4:0] S_CLEAR   = 5'd16;
   localparam logic [4:0] S_QSCAN   = 5'd17;
   localparam logic [4:0] S_QTAIL   = 5'd18;
   localparam logic [4:0] S_QFINAL  = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       join_ff, join_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      join_in  = join_ff;
      cmd.code = iics_pkg::C_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.code = iics_pkg::C_LOAD;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.code = iics_pkg::C_START;
            join_in  = 1'b0;
            case (stat.op)
               iics_pkg::REQ_ADD:   state_in = stat.add_ok ? S_FIND : S_BAD;
               iics_pkg::REQ_CLEAR: state_in = S_CLEAR;
               iics_pkg::REQ_CONTAINS, iics_pkg::REQ_COVERED,
               iics_pkg::REQ_LARGEST, iics_pkg::REQ_LIST: state_in = S_QSCAN;
               default: state_in = S_BAD;
            endcase
         end
         S_FIND: begin
            cmd.code = iics_pkg::C_FIND;
            if (!stat.find_more) state_in = S_SPAN;
         end
         S_SPAN: begin
            cmd.code = iics_pkg::C_SPAN;
            if (!stat.span_more) state_in = stat.span_any ? S_MERGE : S_NEWSUM;
         end
         S_MERGE: begin
            cmd.code = iics_pkg::C_MERGE;
            state_in = S_COMPACT;
         end
         S_COMPACT: begin
            cmd.code = iics_pkg::C_COMPACT;
            if (!stat.idx_lt) state_in = S_CEND;
         end
         S_CEND: begin
            cmd.code = iics_pkg::C_CEND;
            state_in = join_ff ? S_FIND2 : S_OK;
         end
         S_NEWSUM: begin
            cmd.code = iics_pkg::C_NEWSUM;
            state_in = stat.full ? S_JSCAN : S_INSST;
         end
         S_JSCAN: begin
            cmd.code = iics_pkg::C_JSCAN;
            if (!stat.idx_lt) state_in = S_JWRITE;
         end
         S_JWRITE: begin
            cmd.code = iics_pkg::C_JWRITE;
            join_in  = 1'b1;
            state_in = S_COMPACT;
         end
         S_FIND2: begin
            cmd.code = iics_pkg::C_FIND;
            if (!stat.find_more) state_in = stat.swallowed ? S_OK : S_INSST;
         end
         S_INSST: begin
            cmd.code = iics_pkg::C_INSST;
            state_in = S_INSSH;
         end
         S_INSSH: begin
            cmd.code = iics_pkg::C_INSSH;
            if (!stat.ins_more) state_in = S_INSWR;
         end
         S_INSWR: begin
            cmd.code = iics_pkg::C_INSWR;
            state_in = S_OK;
         end
         S_OK: begin
            cmd.code = iics_pkg::C_OK;
            if (stat.out_free) state_in = S_IDLE;
         end
         S_BAD: begin
            cmd.code = iics_pkg::C_BAD;
            if (stat.out_free) state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.code = iics_pkg::C_CLEAR;
            state_in = S_OK;
         end
         S_QSCAN: begin
            cmd.code = iics_pkg::C_QSCAN;
            if (!stat.idx_lt && !stat.hold) state_in = S_QTAIL;
         end
         S_QTAIL: begin
            cmd.code = iics_pkg::C_QTAIL;
            if (!stat.hold) state_in = S_QFINAL;
         end
         S_QFINAL: begin
            cmd.code = iics_pkg::C_QFINAL;
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         join_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         join_ff  <= join_in;
      end
   end

endmodule

// File: rtl/iics_dpath.sv
module iics_dpath #(
   parameter int CAPACITY = iics_pkg::CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  iics_pkg::cmd_type  cmd,
   output iics_pkg::stat_type stat,
   input  logic [2:0]         req_type,
   input  logic [31:0]        req_lo_index,
   input  logic [31:0]        req_hi_index,
   input  logic [4:0]         req_max_gaps,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic               rsp_hit,
   output logic [32:0]        rsp_amount,
   output logic [31:0]        rsp_gap_first,
   output logic [31:0]        rsp_gap_last,
   output logic               rsp_gap_valid,
   output logic               rsp_last_of_run,
   output logic [32:0]        rsp_covered_total,
   output logic               rsp_overflowed,
   output logic [31:0]        rsp_dropped_count,
   output logic [31:0]        rsp_bound_low,
   output logic [31:0]        rsp_bound_high
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic [31:0] first_ff [CAPACITY];
   logic [31:0] last_ff  [CAPACITY];

   logic [2:0]  op_ff;
   logic [31:0] lo_ff, hi_ff;
   logic [4:0]  limit_ff;
   logic [CW-1:0] count_ff, idx_ff, pos_ff, wp_ff, best_ff;
   logic [31:0] mf_ff, ml_ff, prevlast_ff, pend_f_ff, pend_l_ff;
   logic [32:0] before_ff, bestgap_ff, cursor_ff, largest_ff, acc_ff;
   logic [32:0] sum_ff;
   logic [31:0] drop_ff, min_ff, max_ff;
   logic        flag_ff, seen_ff, hit_ff, pend_v_ff;
   logic [4:0]  n_ff;
   logic        rsp_valid_ff;

   logic [CW-1:0] rd_sel;
   logic [IW-1:0] rd_addr, wa;
   logic [31:0]   rd_f, rd_l, wdf, wdl;
   logic          wf_en, wl_en;

   logic idx_lt, find_more, span_more, win_ok, listing, n_ok, act, sc_found, tl_found;
   logic found, hold, out_free, out_load;
   logic [32:0] sc_gap, tl_gap, new_cursor;
   logic [31:0] ov_l, ov_h, jgap;

   logic [1:0]  o_status;
   logic        o_hit, o_gv, o_last;
   logic [32:0] o_amount;
   logic [31:0] o_gf, o_gl;

   assign rd_sel  = (cmd.code == iics_pkg::C_INSSH) ? idx_ff - 1'b1 : idx_ff;
   assign rd_addr = rd_sel[IW-1:0];
   assign rd_f    = first_ff[rd_addr];
   assign rd_l    = last_ff[rd_addr];

   assign idx_lt    = idx_ff < count_ff;
   assign find_more = idx_lt && ({1'b0, rd_l} + 33'd1 < {1'b0, lo_ff});
   assign span_more = idx_lt && ({1'b0, rd_f} <= {1'b0, hi_ff} + 33'd1);
   assign win_ok    = lo_ff <= hi_ff;
   assign listing   = op_ff == iics_pkg::REQ_LIST;
   assign n_ok      = !listing || (n_ff < limit_ff);
   assign act       = win_ok && n_ok && (rd_l >= lo_ff) && (rd_f <= hi_ff);
   assign sc_found  = act && ({1'b0, rd_f} > cursor_ff);
   assign sc_gap    = {1'b0, rd_f} - cursor_ff;
   assign tl_found  = win_ok && (cursor_ff <= {1'b0, hi_ff}) && n_ok;
   assign tl_gap    = {1'b0, hi_ff} - cursor_ff + 33'd1;
   assign new_cursor = {1'b0, rd_l} + 33'd1;
   assign ov_l      = (rd_f > lo_ff) ? rd_f : lo_ff;
   assign ov_h      = (rd_l < hi_ff) ? rd_l : hi_ff;
   assign jgap      = rd_f - prevlast_ff;

   assign found = ((cmd.code == iics_pkg::C_QSCAN) && idx_lt && sc_found) ||
                  ((cmd.code == iics_pkg::C_QTAIL) && tl_found);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign hold     = found && listing && pend_v_ff && !out_free;

   assign stat.op        = op_ff;
   assign stat.add_ok    = win_ok;
   assign stat.find_more = find_more;
   assign stat.span_more = span_more;
   assign stat.span_any  = idx_ff != pos_ff;
   assign stat.full      = count_ff >= CW'(CAPACITY);
   assign stat.idx_lt    = idx_lt;
   assign stat.ins_more  = idx_ff > pos_ff;
   assign stat.swallowed = idx_lt && (rd_f <= lo_ff);
   assign stat.hold      = hold;
   assign stat.out_free  = out_free;

   always_comb begin
      wf_en = 1'b0;
      wl_en = 1'b0;
      wa    = pos_ff[IW-1:0];
      wdf   = rd_f;
      wdl   = rd_l;
      case (cmd.code)
         iics_pkg::C_MERGE: begin
            wf_en = 1'b1; wl_en = 1'b1; wdf = mf_ff; wdl = ml_ff;
         end
         iics_pkg::C_COMPACT: begin
            wf_en = idx_lt; wl_en = idx_lt; wa = wp_ff[IW-1:0];
         end
         iics_pkg::C_JWRITE: begin
            wl_en = 1'b1; wa = best_ff[IW-1:0];
         end
         iics_pkg::C_INSSH: begin
            wf_en = stat.ins_more; wl_en = stat.ins_more; wa = idx_ff[IW-1:0];
         end
         iics_pkg::C_INSWR: begin
            wf_en = 1'b1; wl_en = 1'b1; wdf = lo_ff; wdl = hi_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      out_load = 1'b0;
      o_status = iics_pkg::ST_OK;
      o_hit    = 1'b0;
      o_amount = '0;
      o_gf     = '0;
      o_gl     = '0;
      o_gv     = 1'b0;
      o_last   = 1'b1;
      case (cmd.code)
         iics_pkg::C_OK: out_load = out_free;
         iics_pkg::C_BAD: begin
            out_load = out_free;
            o_status = iics_pkg::ST_BAD;
         end
         iics_pkg::C_QSCAN, iics_pkg::C_QTAIL: begin
            out_load = found && listing && pend_v_ff && out_free;
            o_gf     = pend_f_ff;
            o_gl     = pend_l_ff;
            o_gv     = 1'b1;
            o_last   = 1'b0;
         end
         iics_pkg::C_QFINAL: begin
            out_load = out_free;
            case (op_ff)
               iics_pkg::REQ_CONTAINS: o_hit = hit_ff;
               iics_pkg::REQ_COVERED:  o_amount = acc_ff;
               iics_pkg::REQ_LARGEST:
                  o_amount = largest_ff[32] ? {1'b0, iics_pkg::WORD_MAX} : largest_ff;
               default: begin
                  o_gf = pend_v_ff ? pend_f_ff : 32'd0;
                  o_gl = pend_v_ff ? pend_l_ff : 32'd0;
                  o_gv = pend_v_ff;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wf_en) first_ff[wa] <= wdf;
      if (wl_en) last_ff[wa]  <= wdl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         drop_ff      <= '0;
         flag_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
         pend_v_ff    <= 1'b0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff      <= 1'b1;
            rsp_status        <= o_status;
            rsp_hit           <= o_hit;
            rsp_amount        <= o_amount;
            rsp_gap_first     <= o_gf;
            rsp_gap_last      <= o_gl;
            rsp_gap_valid     <= o_gv;
            rsp_last_of_run   <= o_last;
            rsp_covered_total <= sum_ff;
            rsp_overflowed    <= flag_ff;
            rsp_dropped_count <= drop_ff;
            rsp_bound_low     <= min_ff;
            rsp_bound_high    <= max_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.code)
            iics_pkg::C_LOAD: begin
               op_ff    <= req_type;
               lo_ff    <= req_lo_index;
               hi_ff    <= req_hi_index;
               limit_ff <= (req_max_gaps > 5'(iics_pkg::MAX_RESULTS)) ?
                           5'(iics_pkg::MAX_RESULTS) : req_max_gaps;
            end
            iics_pkg::C_START: begin
               idx_ff     <= '0;
               cursor_ff  <= {1'b0, lo_ff};
               largest_ff <= '0;
               n_ff       <= '0;
               pend_v_ff  <= 1'b0;
               acc_ff     <= '0;
               hit_ff     <= 1'b0;
               if (op_ff == iics_pkg::REQ_ADD && win_ok) begin
                  seen_ff <= 1'b1;
                  if (!seen_ff || lo_ff < min_ff) min_ff <= lo_ff;
                  if (!seen_ff || hi_ff > max_ff) max_ff <= hi_ff;
               end
            end
            iics_pkg::C_FIND: begin
               if (find_more) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  pos_ff    <= idx_ff;
                  mf_ff     <= lo_ff;
                  ml_ff     <= hi_ff;
                  before_ff <= '0;
               end
            end
            iics_pkg::C_SPAN: begin
               if (span_more) begin
                  if (rd_f < mf_ff) mf_ff <= rd_f;
                  if (rd_l > ml_ff) ml_ff <= rd_l;
                  before_ff <= before_ff + ({1'b0, rd_l} - {1'b0, rd_f} + 33'd1);
                  idx_ff    <= idx_ff + 1'b1;
               end
            end
            iics_pkg::C_MERGE: begin
               sum_ff <= sum_ff + ({1'b0, ml_ff} - {1'b0, mf_ff} + 33'd1) - before_ff;
               wp_ff  <= pos_ff + 1'b1;
            end
            iics_pkg::C_COMPACT: begin
               if (idx_lt) begin
                  idx_ff <= idx_ff + 1'b1;
                  wp_ff  <= wp_ff + 1'b1;
               end
            end
            iics_pkg::C_CEND: begin
               count_ff <= wp_ff;
               idx_ff   <= '0;
            end
            iics_pkg::C_NEWSUM: begin
               sum_ff     <= sum_ff + ({1'b0, hi_ff} - {1'b0, lo_ff} + 33'd1);
               idx_ff     <= '0;
               bestgap_ff <= '1;
               best_ff    <= '0;
            end
            iics_pkg::C_JSCAN: begin
               if (idx_lt) begin
                  if (idx_ff != '0 && {1'b0, jgap} < bestgap_ff) begin
                     best_ff    <= idx_ff - 1'b1;
                     bestgap_ff <= {1'b0, jgap};
                  end
                  prevlast_ff <= rd_l;
                  idx_ff      <= idx_ff + 1'b1;
               end else begin
                  idx_ff <= best_ff + 1'b1;
               end
            end
            iics_pkg::C_JWRITE: begin
               wp_ff   <= best_ff + 1'b1;
               idx_ff  <= best_ff + CW'(2);
               flag_ff <= 1'b1;
               if (drop_ff != iics_pkg::WORD_MAX) drop_ff <= drop_ff + 1'b1;
            end
            iics_pkg::C_INSST: idx_ff <= count_ff;
            iics_pkg::C_INSSH: begin
               if (stat.ins_more) idx_ff <= idx_ff - 1'b1;
            end
            iics_pkg::C_INSWR: count_ff <= count_ff + 1'b1;
            iics_pkg::C_CLEAR: begin
               count_ff <= '0;
               sum_ff   <= '0;
               drop_ff  <= '0;
               flag_ff  <= 1'b0;
               seen_ff  <= 1'b0;
               min_ff   <= '0;
               max_ff   <= '0;
            end
            iics_pkg::C_QSCAN: begin
               if (idx_lt && !hold) begin
                  if (lo_ff >= rd_f && lo_ff <= rd_l) hit_ff <= 1'b1;
                  if (win_ok && ov_l <= ov_h)
                     acc_ff <= acc_ff + ({1'b0, ov_h} - {1'b0, ov_l} + 33'd1);
                  if (act && new_cursor > cursor_ff) cursor_ff <= new_cursor;
                  if (sc_found) begin
                     if (sc_gap > largest_ff) largest_ff <= sc_gap;
                     if (listing) begin
                        pend_v_ff <= 1'b1;
                        pend_f_ff <= cursor_ff[31:0];
                        pend_l_ff <= rd_f - 32'd1;
                        n_ff      <= n_ff + 1'b1;
                     end
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            iics_pkg::C_QTAIL: begin
               if (!hold && tl_found) begin
                  if (tl_gap > largest_ff) largest_ff <= tl_gap;
                  if (listing) begin
                     pend_v_ff <= 1'b1;
                     pend_f_ff <= cursor_ff[31:0];
                     pend_l_ff <= hi_ff;
                     n_ff      <= n_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("interval count above capacity");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("response overwritten while stalled");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.code == iics_pkg::C_INSWR) |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("insert did not grow the list");

   a_pend_counted: assert property (@(posedge clock) disable iff (reset)
      pend_v_ff |-> n_ff != 5'd0)
      else $error("pending gap not counted");

endmodule

// File: rtl/index_interval_coverage_set_unit.sv
// Sorted interval set with coverage queries.
// Request channel (req_valid/req_stall): req_type selects add, contains,
// covered count, largest gap, list gaps or clear; lo/hi give the interval,
// window or test index, max_gaps caps the gap listing.
// Response channel (rsp_valid/rsp_stall): one response per request, except
// list gaps: one response per gap, last_of_run on the final, or one if none.
// Every response carries the state totals after the request.
// One request is worked at a time; req_stall is high from acceptance until
// the final response is loaded into the output register, and the next
// request can be taken in the following cycle.
// A query scans one stored interval per cycle unless a listing holds its
// scan; an add searches for its place and spans the intervals it touches,
// then merges them and compacts the list, or inserts a new entry. An add
// into a full list adds a closest-pair scan, a compaction and a second
// search; the default capacity is 16.
// The response register holds while rsp_stall is high; a listing pauses
// its scan when a second gap is found before the first has been taken.
// Reset empties the list and clears totals, flags and bounds; the interval
// storage itself is not cleared.
module index_interval_coverage_set_unit #(
   parameter int CAPACITY = iics_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_lo_index,
   input  logic [31:0] req_hi_index,
   input  logic [4:0]  req_max_gaps,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_hit,
   output logic [32:0] rsp_amount,
   output logic [31:0] rsp_gap_first,
   output logic [31:0] rsp_gap_last,
   output logic        rsp_gap_valid,
   output logic        rsp_last_of_run,
   output logic [32:0] rsp_covered_total,
   output logic        rsp_overflowed,
   output logic [31:0] rsp_dropped_count,
   output logic [31:0] rsp_bound_low,
   output logic [31:0] rsp_bound_high
);

   iics_pkg::cmd_type  cmd;
   iics_pkg::stat_type stat;

   iics_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   iics_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_lo_index      (req_lo_index),
      .req_hi_index      (req_hi_index),
      .req_max_gaps      (req_max_gaps),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_hit           (rsp_hit),
      .rsp_amount        (rsp_amount),
      .rsp_gap_first     (rsp_gap_first),
      .rsp_gap_last      (rsp_gap_last),
      .rsp_gap_valid     (rsp_gap_valid),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_covered_total (rsp_covered_total),
      .rsp_overflowed    (rsp_overflowed),
      .rsp_dropped_count (rsp_dropped_count),
      .rsp_bound_low     (rsp_bound_low),
      .rsp_bound_high    (rsp_bound_high)
   );

endmodule

// File: tb/testbench.sv
module testbench;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [4:0]  max_gaps;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [32:0] amount;
      logic [31:0] gap_first;
      logic [31:0] gap_last;
      logic        gap_valid;
      logic        last_of_run;
      logic [32:0] covered_total;
      logic        overflowed;
      logic [31:0] dropped_count;
      logic [31:0] bound_low;
      logic [31:0] bound_high;
   } answer_type;

   localparam int SLOTS = iics_pkg::CAPACITY_DEF;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_type = 0;
   logic [31:0] req_lo_index = 0;
   logic [31:0] req_hi_index = 0;
   logic [4:0]  req_max_gaps = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic        rsp_hit;
   logic [32:0] rsp_amount;
   logic [31:0] rsp_gap_first;
   logic [31:0] rsp_gap_last;
   logic        rsp_gap_valid;
   logic        rsp_last_of_run;
   logic [32:0] rsp_covered_total;
   logic        rsp_overflowed;
   logic [31:0] rsp_dropped_count;
   logic [31:0] rsp_bound_low;
   logic [31:0] rsp_bound_high;

   index_interval_coverage_set_unit i_dut (.*);

   always #5 clock = ~clock;

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   int       error_count = 0;
   int       request_count = 0;
   int       answer_count = 0;
   int       gap_answer_count = 0;
   bit       stimulus_done = 0;
   bit       pause_sender = 0;
   int       hold_off_cycles = 0;

   logic [31:0] span_first[SLOTS];
   logic [31:0] span_last[SLOTS];
   int          span_count;
   logic [32:0] covered_sum;
   logic [31:0] drop_tally;
   logic        overflow_flag;
   logic        bounds_seen;
   logic [31:0] min_seen;
   logic [31:0] max_seen;

   function automatic void clear_set();
      span_count = 0;
      covered_sum = 0;
      drop_tally = 0;
      overflow_flag = 0;
      bounds_seen = 0;
      min_seen = 0;
      max_seen = 0;
   endfunction

   function automatic void push_answer(logic [1:0] st, logic h, logic [32:0] amt,
                                       logic [31:0] gf, logic [31:0] gl, logic gv,
                                       logic lr);
      answer_type a;
      a.status = st;
      a.hit = h;
      a.amount = amt;
      a.gap_first = gf;
      a.gap_last = gl;
      a.gap_valid = gv;
      a.last_of_run = lr;
      a.covered_total = covered_sum;
      a.overflowed = overflow_flag;
      a.dropped_count = drop_tally;
      a.bound_low = bounds_seen ? min_seen : 32'd0;
      a.bound_high = bounds_seen ? max_seen : 32'd0;
      expected_answers.push_back(a);
   endfunction

   function automatic int insert_slot(logic [31:0] a);
      int p = 0;
      while (p < span_count && {32'd0, span_last[p]} + 64'd1 < {32'd0, a}) p++;
      return p;
   endfunction

   function automatic void join_nearest();
      int best = 0;
      logic [32:0] nearest = '1;
      logic [32:0] g;
      if (span_count < 2) return;
      for (int i = 0; i + 1 < span_count; i++) begin
         g = {1'b0, span_first[i + 1]} - {1'b0, span_last[i]};
         if (g < nearest) begin
            nearest = g;
            best = i;
         end
      end
      span_last[best] = span_last[best + 1];
      for (int i = best + 1; i + 1 < span_count; i++) begin
         span_first[i] = span_first[i + 1];
         span_last[i] = span_last[i + 1];
      end
      span_count--;
      if (drop_tally != iics_pkg::WORD_MAX) drop_tally++;
      overflow_flag = 1;
   endfunction

   function automatic logic [1:0] add_span(logic [31:0] a, logic [31:0] b);
      int pos, stop;
      logic [31:0] mf, ml;
      logic [32:0] prior;
      if (a > b) return iics_pkg::ST_BAD;
      if (!bounds_seen) begin
         bounds_seen = 1;
         min_seen = a;
         max_seen = b;
      end else begin
         if (a < min_seen) min_seen = a;
         if (b > max_seen) max_seen = b;
      end
      pos = insert_slot(a);
      stop = pos;
      while (stop < span_count && {1'b0, span_first[stop]} <= {1'b0, b} + 33'd1) stop++;
      if (stop > pos) begin
         mf = a;
         ml = b;
         prior = 0;
         for (int i = pos; i < stop; i++) begin
            if (span_first[i] < mf) mf = span_first[i];
            if (span_last[i] > ml) ml = span_last[i];
            prior += {1'b0, span_last[i]} - {1'b0, span_first[i]} + 33'd1;
         end
         span_first[pos] = mf;
         span_last[pos] = ml;
         for (int i = stop; i < span_count; i++) begin
            span_first[pos + 1 + i - stop] = span_first[i];
            span_last[pos + 1 + i - stop] = span_last[i];
         end
         span_count -= stop - pos - 1;
         covered_sum = covered_sum + ({1'b0, ml} - {1'b0, mf} + 33'd1) - prior;
         return iics_pkg::ST_OK;
      end
      covered_sum = covered_sum + ({1'b0, b} - {1'b0, a} + 33'd1);
      if (span_count >= SLOTS) begin
         join_nearest();
         pos = insert_slot(a);
         if (pos < span_count && span_first[pos] <= a) return iics_pkg::ST_OK;
      end
      for (int i = span_count; i > pos; i--) begin
         span_first[i] = span_first[i - 1];
         span_last[i] = span_last[i - 1];
      end
      span_first[pos] = a;
      span_last[pos] = b;
      span_count++;
      return iics_pkg::ST_OK;
   endfunction

   function automatic void predict_answers(request_type r);
      logic        h;
      logic [32:0] total, cursor, largest, g;
      logic [31:0] lf, ll, cl, ch;
      int          limit, n;
      bit          listing;
      case (r.kind)
         iics_pkg::REQ_ADD: begin
            logic [1:0] st;
            st = add_span(r.lo, r.hi);
            push_answer(st, 0, 0, 0, 0, 0, 1);
         end
         iics_pkg::REQ_CONTAINS: begin
            h = 0;
            for (int i = 0; i < span_count; i++) begin
               if (r.lo >= span_first[i] && r.lo <= span_last[i]) begin
                  h = 1;
                  break;
               end
               if (span_first[i] > r.lo) break;
            end
            push_answer(iics_pkg::ST_OK, h, 0, 0, 0, 0, 1);
         end
         iics_pkg::REQ_COVERED: begin
            total = 0;
            if (r.lo <= r.hi)
               for (int i = 0; i < span_count; i++) begin
                  cl = span_first[i] > r.lo ? span_first[i] : r.lo;
                  ch = span_last[i] < r.hi ? span_last[i] : r.hi;
                  if (cl <= ch) total += {1'b0, ch} - {1'b0, cl} + 33'd1;
               end
            push_answer(iics_pkg::ST_OK, 0, total, 0, 0, 0, 1);
         end
         iics_pkg::REQ_LARGEST, iics_pkg::REQ_LIST: begin
            listing = (r.kind == iics_pkg::REQ_LIST);
            limit = r.max_gaps > iics_pkg::MAX_RESULTS ? iics_pkg::MAX_RESULTS : r.max_gaps;
            cursor = {1'b0, r.lo};
            largest = 0;
            n = 0;
            if (r.lo <= r.hi && (!listing || limit > 0)) begin
               for (int i = 0; i < span_count; i++) begin
                  lf = span_first[i];
                  ll = span_last[i];
                  if (listing && n >= limit) break;
                  if (ll < r.lo) continue;
                  if (lf > r.hi) break;
                  if ({1'b0, lf} > cursor) begin
                     g = {1'b0, lf} - cursor;
                     if (g > largest) largest = g;
                     if (listing) begin
                        push_answer(iics_pkg::ST_OK, 0, 0, cursor[31:0], lf - 32'd1, 1, 0);
                        n++;
                     end
                  end
                  if ({1'b0, ll} + 33'd1 > cursor) cursor = {1'b0, ll} + 33'd1;
               end
               if (cursor <= {1'b0, r.hi} && (!listing || n < limit)) begin
                  g = {1'b0, r.hi} - cursor + 33'd1;
                  if (g > largest) largest = g;
                  if (listing) begin
                     push_answer(iics_pkg::ST_OK, 0, 0, cursor[31:0], r.hi, 1, 0);
                     n++;
                  end
               end
            end
            if (!listing) begin
               if (largest > {1'b0, iics_pkg::WORD_MAX}) largest = {1'b0, iics_pkg::WORD_MAX};
               push_answer(iics_pkg::ST_OK, 0, largest, 0, 0, 0, 1);
            end else if (n == 0) begin
               push_answer(iics_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
            end else begin
               expected_answers[expected_answers.size() - 1].last_of_run = 1;
               gap_answer_count += n;
            end
         end
         iics_pkg::REQ_CLEAR: begin
            clear_set();
            push_answer(iics_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
         end
         default: push_answer(iics_pkg::ST_BAD, 0, 0, 0, 0, 0, 1);
      endcase
   endfunction

   task automatic report_mismatch(string field, logic [32:0] got, logic [32:0] want);
      $display("error: answer %0d field %s got %h expected %h",
               answer_count, field, got, want);
      error_count++;
   endtask

   // driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      request_type r;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_answers({req_type, req_lo_index, req_hi_index, req_max_gaps});
            request_count++;
         end
         if (req_valid && req_stall) begin
         end else if (pause_sender || pending_requests.size() == 0) begin
            req_valid <= 0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else begin
            r = pending_requests.pop_front();
            req_valid <= 1;
            req_type <= r.kind;
            req_lo_index <= r.lo;
            req_hi_index <= r.hi;
            req_max_gaps <= r.max_gaps;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 8);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            end
         end
      end
   end

   // monitor with its own stall pattern
   always @(posedge clock) begin
      answer_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               $display("error: unexpected answer %0d", answer_count);
               error_count++;
            end else begin
               e = expected_answers.pop_front();
               if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
               if (rsp_hit !== e.hit) report_mismatch("hit", rsp_hit, e.hit);
               if (rsp_amount !== e.amount) report_mismatch("amount", rsp_amount, e.amount);
               if (rsp_gap_first !== e.gap_first)
                  report_mismatch("gap_first", rsp_gap_first, e.gap_first);
               if (rsp_gap_last !== e.gap_last)
                  report_mismatch("gap_last", rsp_gap_last, e.gap_last);
               if (rsp_gap_valid !== e.gap_valid)
                  report_mismatch("gap_valid", rsp_gap_valid, e.gap_valid);
               if (rsp_last_of_run !== e.last_of_run)
                  report_mismatch("last_of_run", rsp_last_of_run, e.last_of_run);
               if (rsp_covered_total !== e.covered_total)
                  report_mismatch("covered_total", rsp_covered_total, e.covered_total);
               if (rsp_overflowed !== e.overflowed)
                  report_mismatch("overflowed", rsp_overflowed, e.overflowed);
               if (rsp_dropped_count !== e.dropped_count)
                  report_mismatch("dropped_count", rsp_dropped_count, e.dropped_count);
               if (rsp_bound_low !== e.bound_low)
                  report_mismatch("bound_low", rsp_bound_low, e.bound_low);
               if (rsp_bound_high !== e.bound_high)
                  report_mismatch("bound_high", rsp_bound_high, e.bound_high);
            end
            answer_count++;
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_stall <= 1;
         end else if (request_count % 64 < 32) begin
            rsp_stall <= 0;
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   function automatic void queue_request(logic [2:0] k, logic [31:0] lo, logic [31:0] hi,
                                         logic [4:0] mg);
      pending_requests.push_back({k, lo, hi, mg});
   endfunction

   function automatic logic [31:0] random_index(logic [31:0] base);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
         2: return $urandom_range(0, 40);
         default: return base + $urandom_range(0, 300);
      endcase
   endfunction

   initial begin
      logic [31:0] base, a, b;
      clear_set();
      repeat (6) @(posedge clock);
      reset <= 0;

      queue_request(iics_pkg::REQ_LIST, 0, 32'hFFFF_FFFF, 5'd31);
      queue_request(iics_pkg::REQ_LARGEST, 0, 32'hFFFF_FFFF, 0);
      queue_request(iics_pkg::REQ_ADD, 0, 0, 0);
      queue_request(iics_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      queue_request(iics_pkg::REQ_ADD, 10, 5, 0);
      queue_request(iics_pkg::REQ_ADD, 1, 9, 0);
      queue_request(iics_pkg::REQ_ADD, 20, 30, 0);
      queue_request(iics_pkg::REQ_ADD, 31, 40, 0);
      queue_request(iics_pkg::REQ_ADD, 15, 35, 0);
      queue_request(iics_pkg::REQ_CONTAINS, 0, 0, 0);
      queue_request(iics_pkg::REQ_CONTAINS, 12, 0, 0);
      queue_request(iics_pkg::REQ_COVERED, 0, 32'hFFFF_FFFF, 0);
      queue_request(iics_pkg::REQ_COVERED, 9, 3, 0);
      queue_request(iics_pkg::REQ_LARGEST, 0, 32'hFFFF_FFFF, 0);
      queue_request(iics_pkg::REQ_LARGEST, 9, 3, 0);
      queue_request(iics_pkg::REQ_LIST, 0, 100, 5'd0);
      queue_request(iics_pkg::REQ_LIST, 0, 100, 5'd1);
      queue_request(iics_pkg::REQ_LIST, 9, 3, 5'd4);
      queue_request(iics_pkg::REQ_LIST, 0, 5, 5'd4);
      queue_request(3'd6, 1, 2, 5'd3);
      queue_request(3'd7, 32'hFFFF_FFFF, 0, 5'd31);
      for (int i = 0; i < 20; i++)
         queue_request(iics_pkg::REQ_ADD, 1000 + 10 * i, 1002 + 10 * i + i % 3, 0);
      queue_request(iics_pkg::REQ_LIST, 0, 32'hFFFF_FFFF, 5'd31);
      queue_request(iics_pkg::REQ_CLEAR, 0, 0, 0);
      queue_request(iics_pkg::REQ_LIST, 0, 32'hFFFF_FFFF, 5'd17);

      // fill while the receiver holds off
      hold_off_cycles = 400;
      while (pending_requests.size() > 0) @(posedge clock);
      pause_sender = 1;
      while (expected_answers.size() > 0 || req_stall || req_valid) @(posedge clock);
      pause_sender = 0;

      base = $urandom;
      for (int i = 0; i < 230; i++) begin
         a = random_index(base);
         b = ($urandom_range(0, 7) == 0) ? random_index(base) : a + $urandom_range(0, 20);
         if (b < a && $urandom_range(0, 3) != 0) b = a;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: queue_request(iics_pkg::REQ_ADD, a, b, 0);
            8, 9: queue_request(iics_pkg::REQ_CONTAINS, a, b, 0);
            10, 11: queue_request(iics_pkg::REQ_COVERED, base,
                                  base + $urandom_range(0, 400), 0);
            12: queue_request(iics_pkg::REQ_COVERED, a, b, 0);
            13, 14: queue_request(iics_pkg::REQ_LARGEST, ($urandom_range(0, 1) ? 0 : a),
                                  ($urandom_range(0, 1) ? 32'hFFFF_FFFF : b), 0);
            15, 16, 17: queue_request(iics_pkg::REQ_LIST, ($urandom_range(0, 1) ? base : a),
                                      ($urandom_range(0, 1) ? 32'hFFFF_FFFF : b),
                                      5'($urandom_range(0, 31)));
            18: if ($urandom_range(0, 4) == 0) begin
               queue_request(iics_pkg::REQ_CLEAR, a, b, 0);
               base = $urandom;
            end else queue_request(iics_pkg::REQ_ADD, a, b, 0);
            default: queue_request(3'($urandom_range(6, 7)), a, b, 5'($urandom_range(0, 31)));
         endcase
      end
      while (pending_requests.size() > 0) @(posedge clock);
      while (expected_answers.size() > 0 || req_valid) @(posedge clock);
      repeat (100) @(posedge clock);
      stimulus_done = 1;
      $display("run covered %0d requests and %0d answers, %0d of them gaps",
               request_count, answer_count, gap_answer_count);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("timeout");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
